// ----- rtl/core/sliding_window_sender_fast_retx_core_macros.svh -----
// Assertion shorthands for the go-back-N sender core.
`ifndef SLIDING_WINDOW_SENDER_FAST_RETX_CORE_MACROS_SVH
`define SLIDING_WINDOW_SENDER_FAST_RETX_CORE_MACROS_SVH

// Same-cycle implication.
`define SWSFR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swsfr: assertion failed");

// Next-cycle implication.
`define SWSFR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swsfr: assertion failed");

`endif

// ----- rtl/core/swsfr_pkg.sv -----
`default_nettype none

package swsfr_pkg;

   // Request kinds; the fourth code is unused and gives an empty result.
   typedef enum logic [1:0] {
      REQ_SEND    = 2'd0,
      REQ_ACK     = 2'd1,
      REQ_TIMEOUT = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      TMR_NONE    = 2'd0,
      TMR_START   = 2'd1,
      TMR_STOP    = 2'd2,
      TMR_RESTART = 2'd3
   } timer_cmd_type;

   localparam int CSR_IDX_W = 4;
   localparam int CFG_W     = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LIMIT  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DUP_THRESHOLD = 4'd1;
   localparam logic [CFG_W-1:0] WIN_RESET = 4'd4;
   localparam logic [CFG_W-1:0] DUP_RESET = 4'd3;

   localparam int DUP_W = 4;
   localparam logic [DUP_W-1:0] DUP_MAX = 4'd15;

   // Longest timeout resend, and the counter that walks it.
   localparam int MAX_RES = 16;
   localparam int WALK_W  = 5;

   typedef struct packed {
      logic capture;    // latch request, start slot residue
      logic slot_calc;  // finish residue, launch memory reads
      logic exec;       // decide and emit (or load the resend walk)
      logic walk_rd;    // read payload for the next resend
      logic walk_emit;  // emit one resend
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       slot_free;
      logic       walk_go;
      logic       walk_last;
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/core/swsfr_ram.sv -----
`default_nettype none

module swsfr_ram #(
   parameter  int WIDTH = 64,
   parameter  int DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/swsfr_ctrl.sv -----
`default_nettype none

module swsfr_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic [1:0]            req_type,
   output logic                       req_ready,
   input  wire swsfr_pkg::status_type status,
   output swsfr_pkg::cmd_type         cmd
);
   import swsfr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SLOT,
      ST_EXEC,
      ST_WALK_RD,
      ST_WALK_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (req_type)
                  REQ_ACK, REQ_TIMEOUT: state_in = ST_SLOT;
                  default:              state_in = ST_EXEC;
               endcase
            end
         end
         ST_SLOT: begin
            cmd.slot_calc = 1'b1;
            state_in      = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.slot_free) begin
               cmd.exec = 1'b1;
               if (status.kind == REQ_TIMEOUT && status.walk_go) begin
                  state_in = ST_WALK_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_WALK_RD: begin
            cmd.walk_rd = 1'b1;
            state_in    = ST_WALK_EMIT;
         end
         ST_WALK_EMIT: begin
            if (status.slot_free) begin
               cmd.walk_emit = 1'b1;
               state_in      = status.walk_last ? ST_IDLE : ST_WALK_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/swsfr_dpath.sv -----
`default_nettype none
`include "sliding_window_sender_fast_retx_core_macros.svh"

module swsfr_dpath #(
   parameter int RING_DEPTH   = 16,
   parameter int SEQ_BITS     = 16,
   parameter int PAYLOAD_BITS = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire swsfr_pkg::cmd_type                  cmd,
   output swsfr_pkg::status_type                    status,
   input  wire logic [1:0]                          req_type,
   input  wire logic [PAYLOAD_BITS-1:0]             req_payload_word,
   input  wire logic [SEQ_BITS-1:0]                 req_ack_number,
   input  wire logic                                req_ack_checksum_ok,
   input  wire logic [SEQ_BITS-1:0]                 req_expired_seq,
   input  wire logic                                csr_valid,
   input  wire logic [swsfr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [swsfr_pkg::CFG_W-1:0]         csr_wdata,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_valid,
   output logic                                     rsp_send_accepted,
   output logic                                     rsp_tx_valid,
   output logic [SEQ_BITS-1:0]                      rsp_tx_seq,
   output logic [PAYLOAD_BITS-1:0]                  rsp_tx_payload,
   output logic [1:0]                               rsp_timer_cmd,
   output logic [SEQ_BITS-1:0]                      rsp_timer_seq,
   output logic                                     rsp_waiting_flag,
   output logic                                     rsp_last_result
);
   import swsfr_pkg::*;

   localparam int SLOT_W = $clog2(RING_DEPTH);
   localparam int NB     = (SEQ_BITS + 7) / 8;
   localparam int SUM_W  = $clog2(NB * RING_DEPTH);
   localparam int SW     = SEQ_BITS;
   localparam int PW     = PAYLOAD_BITS;

   // ---------------- state ----------------
   logic [SW-1:0]         base_ff, base_in;
   logic [SW-1:0]         next_ff, next_in;
   logic [SLOT_W-1:0]     base_slot_ff, base_slot_in;
   logic [SLOT_W-1:0]     next_slot_ff, next_slot_in;
   logic                  waiting_ff, waiting_in;
   logic [RING_DEPTH-1:0] dup_vld_ff, dup_vld_in;
   logic [CFG_W-1:0]      win_limit_ff, dup_thr_ff;

   // latched request
   logic [1:0]    rq_kind_ff;
   logic [PW-1:0] rq_pay_ff;
   logic [SW-1:0] rq_ack_ff;
   logic          rq_ok_ff;
   logic [SW-1:0] rq_exp_ff;

   // slot residue
   logic [SUM_W-1:0]  mod_sum_ff, mod_sum_in;
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot_red;
   logic [SUM_W:0]    red_a, red_b;
   logic [SW-1:0]     mod_src;
   logic [NB*8-1:0]   mod_src_ext;
   logic [SLOT_W-1:0] res_tbl [NB][256];

   // resend walk
   logic [SW-1:0]     walk_seq_ff, walk_seq_in;
   logic [SLOT_W-1:0] walk_slot_ff, walk_slot_in;
   logic [WALK_W-1:0] walk_cnt_ff, walk_cnt_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          o_acc_ff, o_acc_in;
   logic          o_tx_ff, o_tx_in;
   logic [SW-1:0] o_seq_ff, o_seq_in;
   logic [PW-1:0] o_pay_ff, o_pay_in;
   timer_cmd_type o_tcmd_ff, o_tcmd_in;
   logic [SW-1:0] o_tseq_ff, o_tseq_in;
   logic          o_wait_ff, o_wait_in;
   logic          o_last_ff, o_last_in;
   logic          emit;

   // memories
   logic              pay_we, pay_re, dup_we, dup_re;
   logic [SLOT_W-1:0] pay_raddr;
   logic [PW-1:0]     pay_rdata;
   logic [DUP_W-1:0]  dup_rdata, dup_wdata;

   // decision terms
   logic [SW-1:0]     outst, ack_dist, exp_dist, walk_len, start_seq;
   logic [SLOT_W-1:0] start_slot;
   logic              send_ok, ack_good, exp_in, walk_go, fire, dup_inc;
   logic [DUP_W-1:0]  dup_cur, dup_new;
   logic              slot_free;

   function automatic logic [SLOT_W-1:0] slot_step(input logic [SW-1:0] seq,
                                                   input logic [SLOT_W-1:0] slot);
      logic [SLOT_W-1:0] res;
      if (seq == '1) begin
         res = '0;                      // sequence wraps to zero, slot follows
      end else if (slot == SLOT_W'(RING_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = slot + 1'b1;
      end
      return res;
   endfunction

   // ---------------- slot = seq mod RING_DEPTH ----------------
   // Per-byte residue tables, summed at capture and reduced in the slot cycle.
   for (genvar gi = 0; gi < NB; gi++) begin : g_byte
      localparam longint unsigned POS_RES = (longint'(1) << (8 * gi)) % RING_DEPTH;
      for (genvar gb = 0; gb < 256; gb++) begin : g_ent
         assign res_tbl[gi][gb] = SLOT_W'((longint'(gb) * POS_RES) % RING_DEPTH);
      end
   end

   assign mod_src     = (req_type == REQ_TIMEOUT) ? req_expired_seq : req_ack_number;
   assign mod_src_ext = (NB * 8)'(mod_src);

   always_comb begin
      mod_sum_in = '0;
      for (int i = 0; i < NB; i++) begin
         mod_sum_in = mod_sum_in + SUM_W'(res_tbl[i][mod_src_ext[8*i +: 8]]);
      end
   end

   always_comb begin
      red_a = {1'b0, mod_sum_ff};
      if (red_a >= (SUM_W + 1)'(2 * RING_DEPTH)) begin
         red_a = red_a - (SUM_W + 1)'(2 * RING_DEPTH);
      end
      red_b = red_a;
      if (red_b >= (SUM_W + 1)'(RING_DEPTH)) begin
         red_b = red_b - (SUM_W + 1)'(RING_DEPTH);
      end
      slot_red = SLOT_W'(red_b);
   end

   // ---------------- memories ----------------
   assign pay_re    = cmd.slot_calc | cmd.walk_rd;
   assign pay_raddr = cmd.walk_rd ? walk_slot_ff : base_slot_ff;
   assign dup_re    = cmd.slot_calc;

   swsfr_ram #(.WIDTH(PW), .DEPTH(RING_DEPTH)) u_pay_ram (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (next_slot_ff),
      .wr_data (rq_pay_ff),
      .rd_en   (pay_re),
      .rd_addr (pay_raddr),
      .rd_data (pay_rdata)
   );

   swsfr_ram #(.WIDTH(DUP_W), .DEPTH(RING_DEPTH)) u_dup_ram (
      .clock   (clock),
      .wr_en   (dup_we),
      .wr_addr (slot_ff),
      .wr_data (dup_wdata),
      .rd_en   (dup_re),
      .rd_addr (slot_red),
      .rd_data (dup_rdata)
   );

   // ---------------- decision ----------------
   assign slot_free = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      outst    = next_ff - base_ff;
      send_ok  = ({1'b0, outst} <= (SW + 1)'(win_limit_ff)) &&
                 ({1'b0, outst} <  (SW + 1)'(RING_DEPTH));
      ack_dist = rq_ack_ff - base_ff;
      ack_good = ack_dist < outst;
      // never-counted slots read as zero
      dup_cur  = dup_vld_ff[slot_ff] ? dup_rdata : '0;
      dup_inc  = dup_cur != DUP_MAX;
      dup_new  = dup_cur + 1'b1;
      fire     = dup_inc && (dup_new == dup_thr_ff) && (outst != '0);
      exp_dist = rq_exp_ff - base_ff;
      exp_in   = exp_dist < outst;
      start_seq  = exp_in ? rq_exp_ff : base_ff;
      start_slot = exp_in ? slot_ff : base_slot_ff;
      walk_len = next_ff - start_seq;
      walk_go  = walk_len != '0;
   end

   always_comb begin
      base_in      = base_ff;
      next_in      = next_ff;
      base_slot_in = base_slot_ff;
      next_slot_in = next_slot_ff;
      waiting_in   = waiting_ff;
      dup_vld_in   = dup_vld_ff;
      walk_seq_in  = walk_seq_ff;
      walk_slot_in = walk_slot_ff;
      walk_cnt_in  = walk_cnt_ff;
      pay_we       = 1'b0;
      dup_we       = 1'b0;
      dup_wdata    = dup_new;
      emit         = 1'b0;
      o_acc_in     = 1'b0;
      o_tx_in      = 1'b0;
      o_seq_in     = '0;
      o_pay_in     = '0;
      o_tcmd_in    = TMR_NONE;
      o_tseq_in    = '0;
      o_last_in    = 1'b1;

      if (cmd.exec) begin
         emit = 1'b1;
         unique case (rq_kind_ff)
            REQ_SEND: begin
               if (send_ok) begin
                  pay_we                   = 1'b1;
                  dup_vld_in[next_slot_ff] = 1'b0;
                  o_acc_in  = 1'b1;
                  o_tx_in   = 1'b1;
                  o_seq_in  = next_ff;
                  o_pay_in  = rq_pay_ff;
                  if (outst == '0) begin
                     o_tcmd_in = TMR_START;
                     o_tseq_in = next_ff;
                  end
                  next_in      = next_ff + 1'b1;
                  next_slot_in = slot_step(next_ff, next_slot_ff);
                  waiting_in   = 1'b1;
               end
            end
            REQ_ACK: begin
               if (rq_ok_ff) begin
                  waiting_in = 1'b0;
                  if (ack_good) begin
                     o_tcmd_in    = TMR_STOP;
                     o_tseq_in    = rq_ack_ff;
                     base_in      = rq_ack_ff + 1'b1;
                     base_slot_in = slot_step(rq_ack_ff, slot_ff);
                  end else begin
                     if (dup_inc) begin
                        dup_we              = 1'b1;
                        dup_vld_in[slot_ff] = 1'b1;
                     end
                     o_tx_in   = fire;
                     o_seq_in  = fire ? base_ff : '0;
                     o_pay_in  = fire ? pay_rdata : '0;
                     o_tcmd_in = TMR_RESTART;
                     o_tseq_in = base_ff;
                  end
               end
            end
            REQ_TIMEOUT: begin
               if (walk_go) begin
                  emit         = 1'b0;
                  walk_seq_in  = start_seq;
                  walk_slot_in = start_slot;
                  walk_cnt_in  = (walk_len > SW'(MAX_RES)) ? WALK_W'(MAX_RES)
                                                           : walk_len[WALK_W-1:0];
               end
            end
            default: ;
         endcase
      end else if (cmd.walk_emit) begin
         emit         = 1'b1;
         o_tx_in      = 1'b1;
         o_seq_in     = walk_seq_ff;
         o_pay_in     = pay_rdata;
         o_tcmd_in    = TMR_RESTART;
         o_tseq_in    = walk_seq_ff;
         o_last_in    = walk_cnt_ff == WALK_W'(1);
         walk_seq_in  = walk_seq_ff + 1'b1;
         walk_slot_in = slot_step(walk_seq_ff, walk_slot_ff);
         walk_cnt_in  = walk_cnt_ff - 1'b1;
      end

      o_wait_in = waiting_in;

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         next_ff      <= '0;
         base_slot_ff <= '0;
         next_slot_ff <= '0;
         waiting_ff   <= 1'b0;
         dup_vld_ff   <= '0;
         win_limit_ff <= WIN_RESET;
         dup_thr_ff   <= DUP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         next_ff      <= next_in;
         base_slot_ff <= base_slot_in;
         next_slot_ff <= next_slot_in;
         waiting_ff   <= waiting_in;
         dup_vld_ff   <= dup_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            if (csr_index == CSR_WINDOW_LIMIT) begin
               win_limit_ff <= csr_wdata;
            end else if (csr_index == CSR_DUP_THRESHOLD) begin
               dup_thr_ff <= csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rq_kind_ff <= req_type;
         rq_pay_ff  <= req_payload_word;
         rq_ack_ff  <= req_ack_number;
         rq_ok_ff   <= req_ack_checksum_ok;
         rq_exp_ff  <= req_expired_seq;
         mod_sum_ff <= mod_sum_in;
      end
      if (cmd.slot_calc) begin
         slot_ff <= slot_red;
      end
      walk_seq_ff  <= walk_seq_in;
      walk_slot_ff <= walk_slot_in;
      walk_cnt_ff  <= walk_cnt_in;
      if (emit) begin
         o_acc_ff  <= o_acc_in;
         o_tx_ff   <= o_tx_in;
         o_seq_ff  <= o_seq_in;
         o_pay_ff  <= o_pay_in;
         o_tcmd_ff <= o_tcmd_in;
         o_tseq_ff <= o_tseq_in;
         o_wait_ff <= o_wait_in;
         o_last_ff <= o_last_in;
      end
   end

   assign status.kind      = rq_kind_ff;
   assign status.slot_free = slot_free;
   assign status.walk_go   = walk_go;
   assign status.walk_last = walk_cnt_ff == WALK_W'(1);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_send_accepted = o_acc_ff;
   assign rsp_tx_valid      = o_tx_ff;
   assign rsp_tx_seq        = o_seq_ff;
   assign rsp_tx_payload    = o_pay_ff;
   assign rsp_timer_cmd     = o_tcmd_ff;
   assign rsp_timer_seq     = o_tseq_ff;
   assign rsp_waiting_flag  = o_wait_ff;
   assign rsp_last_result   = o_last_ff;

   // ---------------- assertions ----------------
   `SWSFR_ASSERT_IMP(a_outst_bound, clock, reset, 1'b1, {1'b0, outst} <= (SW + 1)'(RING_DEPTH))
   `SWSFR_ASSERT_IMP(a_walk_cnt_live, clock, reset, cmd.walk_emit, walk_cnt_ff != '0)
   `SWSFR_ASSERT_IMP(a_emit_has_room, clock, reset, cmd.exec || cmd.walk_emit, slot_free)
   `SWSFR_ASSERT_NXT(a_send_advances, clock, reset, cmd.exec && rq_kind_ff == REQ_SEND && send_ok, rsp_valid_ff && o_tx_ff && next_ff == SW'($past(next_ff) + 1'b1))

endmodule

`default_nettype wire

// ----- rtl/core/sliding_window_sender_fast_retx_core.sv -----
// Go-back-N sender with fast retransmit.
// Request channel (req_*): send, acknowledgement or timer-expired events.
// Response channel (rsp_*): transmit / timer commands; rsp_last_result marks
// the final response of a request. Config channel (csr_*): index 0 window
// limit, index 1 duplicate threshold; always ready, write only when idle.
// Steps: send and unknown request go accept, decide; ack and timeout with
// nothing to resend add a slot step between them, which reduces the
// sequence number to a ring slot through per-byte residue tables.
// A timeout with packets to resend goes accept, slot, load walk, payload
// RAM read, emit to the first response, then read, emit for each
// further packet, up to 16 packets.
// Throughput: one request in flight; next request accepted once the last
// response is in the output register, even while that response waits.
// Reset: window empty, sequence numbers 0, duplicate counts 0, window
// limit 4, threshold 3. Payload ring is not cleared; no clearing pass.
// Stall: a stalled rsp_ready holds the output register and the controller
// waits in its decide or resend state; no response is dropped.
`default_nettype none

module sliding_window_sender_fast_retx_core #(
   parameter int RING_DEPTH   = 16,
   parameter int SEQ_BITS     = 16,
   parameter int PAYLOAD_BITS = 64
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [1:0]                      req_type,
   input  wire logic [PAYLOAD_BITS-1:0]         req_payload_word,
   input  wire logic [SEQ_BITS-1:0]             req_ack_number,
   input  wire logic                            req_ack_checksum_ok,
   input  wire logic [SEQ_BITS-1:0]             req_expired_seq,
   // config channel
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [swsfr_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [swsfr_pkg::CFG_W-1:0]     csr_wdata,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_send_accepted,
   output logic                                 rsp_tx_valid,
   output logic [SEQ_BITS-1:0]                  rsp_tx_seq,
   output logic [PAYLOAD_BITS-1:0]              rsp_tx_payload,
   output logic [1:0]                           rsp_timer_cmd,
   output logic [SEQ_BITS-1:0]                  rsp_timer_seq,
   output logic                                 rsp_waiting_flag,
   output logic                                 rsp_last_result
);
   import swsfr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // config registers take a write in any cycle
   assign csr_ready = 1'b1;

   // sequencer: idle -> slot (ack and timeout only) -> decide -> (resend read/emit loop)
   swsfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // window state, payload ring, duplicate counters, response register
   swsfr_dpath #(
      .RING_DEPTH   (RING_DEPTH),
      .SEQ_BITS     (SEQ_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_type            (req_type),
      .req_payload_word    (req_payload_word),
      .req_ack_number      (req_ack_number),
      .req_ack_checksum_ok (req_ack_checksum_ok),
      .req_expired_seq     (req_expired_seq),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_send_accepted   (rsp_send_accepted),
      .rsp_tx_valid        (rsp_tx_valid),
      .rsp_tx_seq          (rsp_tx_seq),
      .rsp_tx_payload      (rsp_tx_payload),
      .rsp_timer_cmd       (rsp_timer_cmd),
      .rsp_timer_seq       (rsp_timer_seq),
      .rsp_waiting_flag    (rsp_waiting_flag),
      .rsp_last_result     (rsp_last_result)
   );

endmodule

`default_nettype wire
